// ----- src/bbcf_pkg.sv -----
// Package for the box blur with centre fill.
// Holds the sequencer states, opcodes and configuration register indexes.
// No dependencies.
package bbcf_pkg;

  localparam int RESULT_CAP = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_WRITE,
    S_CHECK,
    S_START,
    S_CENT,
    S_SUM,
    S_DIV,
    S_SEND
  } state_e;

endpackage

// ----- src/box_blur_center_fill_top.sv -----
// Box blur with centre fill: top level, row store, window sum and serial divider.
// Depends on bbcf_pkg.
//
// Pixels enter in raster order and each filtered pixel leaves once its 2I x 2I
// window has arrived; window places outside the frame count the centre pixel.
// A pixel transfer is stored in the WRAP and WRITE states; each result it releases
// (up to eight) needs 4*I*I row store reads, one per cycle through the single read
// port, and SW quotient bits (16 at the default MAX_RADIUS), one per cycle, from a
// serial divider that runs the three channels in parallel on a shared divisor. A drain
// transfer releases one result once the frame is in. The block is not ready while it works.
module box_blur_center_fill_top #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bbcf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [7:0]                      pixel_red_i,
  input  logic [7:0]                      pixel_green_i,
  input  logic [7:0]                      pixel_blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [9:0]                      out_column_o,
  output logic [9:0]                      out_row_o,
  output logic [7:0]                      mean_red_o,
  output logic [7:0]                      mean_green_o,
  output logic [7:0]                      mean_blue_o,
  output logic                            frame_done_o
);
  import bbcf_pkg::*;

  localparam int S    = 2 * MAX_RADIUS;
  localparam int SLW  = $clog2(S);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int CLW  = $clog2(MAX_WIDTH);
  localparam int AW   = $clog2(S * MAX_WIDTH);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int WCW  = $clog2(2 * MAX_RADIUS);
  localparam int SW   = $clog2(4 * MAX_RADIUS * MAX_RADIUS * 255 + 1);
  localparam int DVW  = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1) + 1;
  localparam int STW  = $clog2(SW);
  localparam int AXW  = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1) + 1;
  localparam int AYW  = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1) + 1;
  localparam int CNTW = $clog2(RESULT_CAP);

  state_e state_q, state_d;

  logic [3:0]            cfg_int_q;
  logic [CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;

  logic [CW-1:0]  in_col_q, emit_col_q;
  logic [RW-1:0]  in_row_q, emit_row_q;
  logic [SLW-1:0] in_slot_q, emit_slot_q;
  logic           frame_rcv_q;
  logic [CNTW-1:0] cnt_q;
  logic           drain_q;
  logic [STW-1:0] step_q;
  logic           out_valid_q;

  logic [23:0]    pix_q;
  logic [23:0]    mem_q [S*MAX_WIDTH];
  logic [23:0]    rd_data_q;
  logic [23:0]    centre_q;
  logic [RADW-1:0] r_q;
  logic [DVW-1:0] div_q;
  logic signed [AXW-1:0] ax0_q, ax_q;
  logic signed [AYW-1:0] ay_q;
  logic [SLW-1:0] ay_slot_q;
  logic [WCW-1:0] wx_q, wy_q;
  logic           issued_q, pend_v_q, pend_mem_q;
  logic [SW-1:0]  sum_q [3];
  logic [DVW-1:0] rem_q [3];
  logic [9:0]     out_col_q, out_row_q;
  logic [7:0]     mean_q [3];
  logic           frame_done_q;

  logic [CW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic [RADW-1:0] r_eff, d_eff;
  logic [CW:0]     nx;
  logic [RW:0]     ny;
  logic            out_rdy;
  logic signed [AXW-1:0] w_s;
  logic signed [AYW-1:0] h_s;
  logic            in_img;
  logic [WCW-1:0]  win_last;
  logic [SLW:0]    slot_tmp;
  logic [SLW-1:0]  slot_start;
  logic [SLW-1:0]  rd_slot;
  logic [CLW-1:0]  rd_col;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [23:0]     pend_pix;
  logic [DVW-1:0]  trial [3];
  logic            send_fire, last_emit;
  logic            col_wrap, frame_end;
  logic            accept;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = CW'(1);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = RW'(1);
    end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg_h_q);
    end
    if (int'(cfg_int_q) > MAX_RADIUS) begin
      r_eff = RADW'(MAX_RADIUS);
    end else begin
      r_eff = RADW'(cfg_int_q);
    end
  end

  always_comb begin
    d_eff = (r_eff == '0) ? '0 : r_eff - 1'b1;
    nx    = (CW+1)'(emit_col_q) + (CW+1)'(d_eff);
    if (nx > (CW+1)'(w_eff - 1'b1)) begin
      nx = (CW+1)'(w_eff - 1'b1);
    end
    ny = (RW+1)'(emit_row_q) + (RW+1)'(d_eff);
    if (ny > (RW+1)'(h_eff - 1'b1)) begin
      ny = (RW+1)'(h_eff - 1'b1);
    end
    out_rdy = frame_rcv_q || (ny < (RW+1)'(in_row_q)) ||
              ((ny == (RW+1)'(in_row_q)) && (nx < (CW+1)'(in_col_q)));
  end

  assign w_s      = AXW'(w_eff);
  assign h_s      = AYW'(h_eff);
  assign in_img   = !ax_q[AXW-1] && (ax_q < w_s) && !ay_q[AYW-1] && (ay_q < h_s);
  assign win_last = WCW'(((RADW+1)'(r_q) << 1) - 1'b1);
  assign pend_pix = pend_mem_q ? rd_data_q : centre_q;

  always_comb begin
    slot_tmp = (SLW+1)'(emit_slot_q) + (SLW+1)'(S) - (SLW+1)'(r_eff);
    if (slot_tmp >= (SLW+1)'(S)) begin
      slot_tmp = slot_tmp - (SLW+1)'(S);
    end
    slot_start = SLW'(slot_tmp);
  end

  always_comb begin
    rd_slot = emit_slot_q;
    rd_col  = CLW'(emit_col_q);
    if (state_q == S_SUM) begin
      rd_slot = in_img ? ay_slot_q : '0;
      rd_col  = in_img ? CLW'(ax_q) : '0;
    end
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);
    wr_addr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
    wr_en   = (state_q == S_WRITE) && (in_row_q < h_eff);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_q[c][DVW-2:0], sum_q[c][SW-1]};
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign send_fire = (state_q == S_SEND) && (!out_valid_q || out_ready_i);
  assign col_wrap  = ((CW+1)'(emit_col_q) + 1'b1) >= (CW+1)'(w_eff);
  assign frame_end = col_wrap && (((RW+1)'(emit_row_q) + 1'b1) >= (RW+1)'(h_eff));
  assign last_emit = drain_q || (cnt_q == CNTW'(RESULT_CAP - 1)) ||
                     (frame_rcv_q && frame_end);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_DRAIN) begin
            if (frame_rcv_q) state_d = S_START;
          end else if (!frame_rcv_q) begin
            state_d = S_WRAP;
          end
        end
      end
      S_WRAP:  state_d = S_WRITE;
      S_WRITE: state_d = S_CHECK;
      S_CHECK: state_d = out_rdy ? S_START : S_IDLE;
      S_START: state_d = (r_eff == '0) ? S_SEND : S_CENT;
      S_CENT:  state_d = S_SUM;
      S_SUM: begin
        if (issued_q && !pend_v_q) state_d = S_DIV;
      end
      S_DIV: begin
        if (step_q == STW'(SW - 1)) state_d = S_SEND;
      end
      S_SEND: begin
        if (send_fire) state_d = last_emit ? S_IDLE : S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_int_q   <= 4'd1;
      cfg_w_q     <= CFG_DATA_W'(640);
      cfg_h_q     <= CFG_DATA_W'(480);
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      emit_col_q  <= '0;
      emit_row_q  <= '0;
      emit_slot_q <= '0;
      frame_rcv_q <= 1'b0;
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INTENSITY: cfg_int_q <= cfg_data_i[3:0];
          CFG_WIDTH:     cfg_w_q   <= cfg_data_i;
          CFG_HEIGHT:    cfg_h_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        drain_q <= (op_i == OP_DRAIN);
        cnt_q   <= '0;
      end
      if ((state_q == S_WRAP) && (in_col_q >= w_eff)) begin
        in_col_q  <= '0;
        in_row_q  <= in_row_q + 1'b1;
        in_slot_q <= (in_slot_q == SLW'(S - 1)) ? '0 : in_slot_q + 1'b1;
      end
      if (state_q == S_WRITE) begin
        if (in_row_q >= h_eff) begin
          frame_rcv_q <= 1'b1;
        end else if (((CW+1)'(in_col_q) + 1'b1) >= (CW+1)'(w_eff)) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 1'b1;
          in_slot_q <= (in_slot_q == SLW'(S - 1)) ? '0 : in_slot_q + 1'b1;
          if (((RW+1)'(in_row_q) + 1'b1) >= (RW+1)'(h_eff)) frame_rcv_q <= 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (state_q == S_START) begin
        step_q <= '0;
      end else if (state_q == S_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (send_fire) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 1'b1;
        if (frame_end) begin
          emit_col_q  <= '0;
          emit_row_q  <= '0;
          emit_slot_q <= '0;
          in_col_q    <= '0;
          in_row_q    <= '0;
          in_slot_q   <= '0;
          frame_rcv_q <= 1'b0;
        end else if (col_wrap) begin
          emit_col_q  <= '0;
          emit_row_q  <= emit_row_q + 1'b1;
          emit_slot_q <= (emit_slot_q == SLW'(S - 1)) ? '0 : emit_slot_q + 1'b1;
        end else begin
          emit_col_q <= emit_col_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= pix_q;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) pix_q <= {pixel_red_i, pixel_green_i, pixel_blue_i};
    case (state_q)
      S_START: begin
        r_q       <= r_eff;
        div_q     <= (DVW'(r_eff) * DVW'(r_eff)) << 2;
        ax0_q     <= AXW'(emit_col_q) - AXW'(r_eff);
        ax_q      <= AXW'(emit_col_q) - AXW'(r_eff);
        ay_q      <= AYW'(emit_row_q) - AYW'(r_eff);
        ay_slot_q <= slot_start;
        wx_q      <= '0;
        wy_q      <= '0;
        issued_q  <= 1'b0;
        pend_v_q  <= 1'b0;
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= '0;
          rem_q[c] <= '0;
        end
      end
      S_CENT: centre_q <= rd_data_q;
      S_SUM: begin
        if (!issued_q) begin
          pend_v_q   <= 1'b1;
          pend_mem_q <= in_img;
          if (wx_q == win_last) begin
            wx_q      <= '0;
            ax_q      <= ax0_q;
            ay_q      <= ay_q + 1'b1;
            ay_slot_q <= (ay_slot_q == SLW'(S - 1)) ? '0 : ay_slot_q + 1'b1;
            if (wy_q == win_last) begin
              issued_q <= 1'b1;
            end else begin
              wy_q <= wy_q + 1'b1;
            end
          end else begin
            wx_q <= wx_q + 1'b1;
            ax_q <= ax_q + 1'b1;
          end
        end else begin
          pend_v_q <= 1'b0;
        end
        if (pend_v_q) begin
          for (int c = 0; c < 3; c++) begin
            sum_q[c] <= sum_q[c] + SW'(pend_pix[23-8*c -: 8]);
          end
        end
      end
      S_DIV: begin
        for (int c = 0; c < 3; c++) begin
          if (trial[c] >= div_q) begin
            rem_q[c] <= trial[c] - div_q;
            sum_q[c] <= {sum_q[c][SW-2:0], 1'b1};
          end else begin
            rem_q[c] <= trial[c];
            sum_q[c] <= {sum_q[c][SW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (send_fire) begin
      out_col_q    <= 10'(emit_col_q);
      out_row_q    <= 10'(emit_row_q);
      frame_done_q <= frame_end;
      for (int c = 0; c < 3; c++) begin
        mean_q[c] <= sum_q[c][7:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign mean_red_o   = mean_q[0];
  assign mean_green_o = mean_q[1];
  assign mean_blue_o  = mean_q[2];
  assign frame_done_o = frame_done_q;

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_fire && frame_end |=> !frame_rcv_q && in_row_q == '0 && in_col_q == '0 &&
    emit_row_q == '0 && emit_col_q == '0)
    else $error("frame end did not clear counters");

  a_sum_nonzero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> r_q != '0)
    else $error("window sum with zero radius");

  a_pixel_starts_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_PIXEL && !frame_rcv_q |=> state_q == S_WRAP)
    else $error("pixel transfer not stored");

  a_div_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> issued_q && !pend_v_q)
    else $error("divide started before window sum complete");

endmodule
